[rtl/core/rle_enc_pkg.sv]
// ----------------------------------------------------------------------------
// rle_enc_pkg
// Shared types, constants and helper functions of the run-length encoder
// with ASCII decimal run counts.
// ----------------------------------------------------------------------------
package rle_enc_pkg;

  // Default and upper bound of the number of BCD digits in a run counter.
  localparam int MaxDigitsDef = 4;
  localparam int MaxDigitsTop = 8;
  localparam int MaxBcdW      = 4 * MaxDigitsTop;

  // Entries in the queue between the front and back parts.
  localparam int QDepth = 2;

  localparam logic [7:0] AsciiZero = 8'h30;
  localparam logic [7:0] AsciiOne  = 8'h31;

  // Flush command for one item: an optional closed run (its length travels
  // next to this struct), then an optional run of length one that a final
  // item opened and closed at once.
  typedef struct packed {
    logic       a_valid;
    logic       b_valid;
    logic       fin;
    logic [7:0] a_val;
    logic [7:0] b_val;
  } rle_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_A_DIG,
    ST_A_VAL,
    ST_B_DIG,
    ST_B_VAL
  } rle_state_t;

  // BCD word with the lowest n digits set to nine.
  function automatic logic [MaxBcdW-1:0] all_nines(input int n);
    logic [MaxBcdW-1:0] v;
    v = '0;
    for (int i = 0; i < MaxDigitsTop; i++) begin
      if (i < n) begin
        v[4*i +: 4] = 4'd9;
      end
    end
    return v;
  endfunction

  // Index of the most significant nonzero digit among the lowest n digits.
  function automatic logic [2:0] top_digit(input logic [MaxBcdW-1:0] bcd, input int n);
    logic [2:0] top;
    top = '0;
    for (int i = 0; i < MaxDigitsTop; i++) begin
      if (i < n && bcd[4*i +: 4] != 4'd0) begin
        top = 3'(i);
      end
    end
    return top;
  endfunction

endpackage

[rtl/core/rle_enc_queue.sv]
// ----------------------------------------------------------------------------
// rle_enc_queue
// Short show-ahead queue of flush commands between the front and back parts.
// ----------------------------------------------------------------------------
module rle_enc_queue #(
  parameter int DataW = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [DataW-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [DataW-1:0] pop_data,
  output logic             not_empty
);

  localparam int PtrW = (rle_enc_pkg::QDepth > 1) ? $clog2(rle_enc_pkg::QDepth) : 1;
  localparam int CntW = $clog2(rle_enc_pkg::QDepth + 1);

  logic [DataW-1:0] mem_r [rle_enc_pkg::QDepth];
  logic [PtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]  count_r, count_nxt;
  logic             do_push, do_pop;

  assign full      = (count_r == CntW'(rle_enc_pkg::QDepth));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(rle_enc_pkg::QDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(rle_enc_pkg::QDepth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[rtl/core/rle_enc_front.sv]
// ----------------------------------------------------------------------------
// rle_enc_front
// Accepts input bytes, keeps the open run and its BCD length, and turns each
// item into at most one flush command for the back part.
// ----------------------------------------------------------------------------
module rle_enc_front #(
  parameter int MaxDigits = rle_enc_pkg::MaxDigitsDef
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  in_data_byte,
  input  logic                        in_final_byte,
  output logic                        q_push,
  output rle_enc_pkg::rle_cmd_t       q_cmd,
  output logic [4*MaxDigits-1:0]      q_len,
  input  logic                        q_full
);

  localparam int LenW = 4 * MaxDigits;
  localparam logic [LenW-1:0] Nines = LenW'(rle_enc_pkg::all_nines(MaxDigits));
  localparam logic [LenW-1:0] LenOne = LenW'(1);

  logic [7:0]      run_value_r, run_value_nxt;
  logic [LenW-1:0] run_len_r, run_len_nxt;
  logic            run_open_r, run_open_nxt;
  logic [LenW-1:0] len_inc;
  logic            accept;
  logic            same;
  logic            cap;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign same     = run_open_r && (run_value_r == in_data_byte);

  // BCD increment: the carry ripples through the digits that hold nine.
  always_comb begin
    logic       carry;
    logic [3:0] d;
    len_inc = run_len_r;
    carry   = 1'b1;
    for (int i = 0; i < MaxDigits; i++) begin
      d = run_len_r[4*i +: 4];
      if (carry) begin
        if (d == 4'd9) begin
          len_inc[4*i +: 4] = 4'd0;
        end else begin
          len_inc[4*i +: 4] = d + 4'd1;
          carry = 1'b0;
        end
      end
    end
  end

  assign cap = (len_inc == Nines);

  always_comb begin
    run_value_nxt = run_value_r;
    run_len_nxt   = run_len_r;
    run_open_nxt  = run_open_r;
    q_cmd         = '0;
    q_len         = run_len_r;
    q_cmd.a_val   = run_value_r;
    q_cmd.b_val   = in_data_byte;
    q_cmd.fin     = in_final_byte;
    if (same) begin
      q_cmd.a_valid = cap || in_final_byte;
      q_len         = len_inc;
      if (cap || in_final_byte) begin
        run_len_nxt  = '0;
        run_open_nxt = 1'b0;
      end else begin
        run_len_nxt = len_inc;
      end
    end else begin
      q_cmd.a_valid = run_open_r;
      q_cmd.b_valid = in_final_byte;
      if (in_final_byte) begin
        run_len_nxt  = '0;
        run_open_nxt = 1'b0;
      end else begin
        run_value_nxt = in_data_byte;
        run_len_nxt   = LenOne;
        run_open_nxt  = 1'b1;
      end
    end
    if (in_final_byte) begin
      run_value_nxt = '0;
    end
  end

  assign q_push = accept && (q_cmd.a_valid || q_cmd.b_valid);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_value_r <= '0;
      run_len_r   <= '0;
      run_open_r  <= 1'b0;
    end else if (accept) begin
      run_value_r <= run_value_nxt;
      run_len_r   <= run_len_nxt;
      run_open_r  <= run_open_nxt;
    end
  end

  // A closed run always has a zero count, and an open one is below the cap.
  a_closed_zero : assert property (@(posedge clk) disable iff (!rst_n)
    !run_open_r |-> run_len_r == '0)
    else $error("closed run holds a nonzero count");

  a_open_below_cap : assert property (@(posedge clk) disable iff (!rst_n)
    run_open_r |-> run_len_r != Nines && run_len_r != '0)
    else $error("open run count at cap or zero");

endmodule

[rtl/core/rle_enc_back.sv]
// ----------------------------------------------------------------------------
// rle_enc_back
// Takes flush commands from the queue and sends out the count digits and the
// run byte, one result item per cycle while out_ready allows, through an output register.
// ----------------------------------------------------------------------------
module rle_enc_back #(
  parameter int MaxDigits = rle_enc_pkg::MaxDigitsDef
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  input  rle_enc_pkg::rle_cmd_t  q_cmd,
  input  logic [4*MaxDigits-1:0] q_len,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [7:0]             out_code_byte,
  output logic                   out_last_of_item,
  output logic                   out_stream_done
);

  localparam int LenW = 4 * MaxDigits;
  localparam int IdxW = (MaxDigits > 1) ? $clog2(MaxDigits) : 1;

  rle_enc_pkg::rle_state_t state_r, state_nxt;
  logic [LenW-1:0] a_len_r, a_len_nxt;
  logic [7:0]      a_val_r, a_val_nxt;
  logic [7:0]      b_val_r, b_val_nxt;
  logic            b_valid_r, b_valid_nxt;
  logic            fin_r, fin_nxt;
  logic [IdxW-1:0] idx_r, idx_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [7:0]      code_r, code_nxt;
  logic            last_r, last_nxt;
  logic            done_r, done_nxt;
  logic [2:0]      head_top;
  logic [3:0]      digit;
  logic            adv;
  logic            finish;
  logic            load;

  assign head_top = rle_enc_pkg::top_digit(rle_enc_pkg::MaxBcdW'(q_len), MaxDigits);
  assign digit    = a_len_r[idx_r*4 +: 4];
  assign adv      = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    a_len_nxt     = a_len_r;
    a_val_nxt     = a_val_r;
    b_val_nxt     = b_val_r;
    b_valid_nxt   = b_valid_r;
    fin_nxt       = fin_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    code_nxt      = code_r;
    last_nxt      = last_r;
    done_nxt      = done_r;
    finish        = 1'b0;
    load          = 1'b0;
    q_pop         = 1'b0;
    if (adv) begin
      out_valid_nxt = 1'b0;
      unique case (state_r)
        rle_enc_pkg::ST_IDLE: begin
          load = q_valid;
        end
        rle_enc_pkg::ST_A_DIG: begin
          out_valid_nxt = 1'b1;
          code_nxt      = rle_enc_pkg::AsciiZero | {4'd0, digit};
          last_nxt      = 1'b0;
          done_nxt      = 1'b0;
          if (idx_r == '0) begin
            state_nxt = rle_enc_pkg::ST_A_VAL;
          end else begin
            idx_nxt = idx_r - 1'b1;
          end
        end
        rle_enc_pkg::ST_A_VAL: begin
          out_valid_nxt = 1'b1;
          code_nxt      = a_val_r;
          last_nxt      = !b_valid_r;
          done_nxt      = !b_valid_r && fin_r;
          if (b_valid_r) begin
            state_nxt = rle_enc_pkg::ST_B_DIG;
          end else begin
            finish = 1'b1;
          end
        end
        rle_enc_pkg::ST_B_DIG: begin
          out_valid_nxt = 1'b1;
          code_nxt      = rle_enc_pkg::AsciiOne;
          last_nxt      = 1'b0;
          done_nxt      = 1'b0;
          state_nxt     = rle_enc_pkg::ST_B_VAL;
        end
        rle_enc_pkg::ST_B_VAL: begin
          out_valid_nxt = 1'b1;
          code_nxt      = b_val_r;
          last_nxt      = 1'b1;
          done_nxt      = fin_r;
          finish        = 1'b1;
        end
        default: begin
          state_nxt = rle_enc_pkg::ST_IDLE;
        end
      endcase
      // The next command is taken in the same cycle as the last byte of the
      // current one, so back-to-back commands leave no gap.
      if (finish) begin
        load = q_valid;
        if (!q_valid) begin
          state_nxt = rle_enc_pkg::ST_IDLE;
        end
      end
      if (load) begin
        q_pop       = 1'b1;
        a_len_nxt   = q_len;
        a_val_nxt   = q_cmd.a_val;
        b_val_nxt   = q_cmd.b_val;
        b_valid_nxt = q_cmd.b_valid;
        fin_nxt     = q_cmd.fin;
        idx_nxt     = head_top[IdxW-1:0];
        state_nxt   = q_cmd.a_valid ? rle_enc_pkg::ST_A_DIG : rle_enc_pkg::ST_B_DIG;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rle_enc_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_len_r   <= a_len_nxt;
    a_val_r   <= a_val_nxt;
    b_val_r   <= b_val_nxt;
    b_valid_r <= b_valid_nxt;
    fin_r     <= fin_nxt;
    idx_r     <= idx_nxt;
    code_r    <= code_nxt;
    last_r    <= last_nxt;
    done_r    <= done_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_code_byte    = code_r;
  assign out_last_of_item = last_r;
  assign out_stream_done  = done_r;

  a_digit_decimal : assert property (@(posedge clk) disable iff (!rst_n)
    state_r == rle_enc_pkg::ST_A_DIG |-> digit <= 4'd9)
    else $error("count digit out of decimal range");

  a_done_is_last : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && done_r |-> last_r)
    else $error("stream end flagged on a result that does not end its item");

  a_single_run_final : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rle_enc_pkg::ST_B_DIG || state_r == rle_enc_pkg::ST_B_VAL)
      |-> b_valid_r && fin_r)
    else $error("single-byte run flushed outside a final item");

  a_pop_nonempty : assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("pop from an empty queue");

endmodule

[rtl/core/rle_decimal_count_encoder.sv]
// ----------------------------------------------------------------------------
// rle_decimal_count_encoder
// Run-length encoder that writes each run as its length in ASCII decimal
// digits followed by the run byte.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready) takes one raw byte per item; set
//   in_final_byte on the last byte of a stream to flush the open run. The
//   output channel (out_valid/out_ready) gives one encoded byte per item,
//   with out_last_of_item on the last result of an input item and
//   out_stream_done on the last result of the stream.
//   Runs are capped at 10^MaxDigits-1 bytes; at the cap the run is sent and
//   the next byte opens a new run.
//   An accepted item's first result passes the command queue, the back
//   part's command registers and the output register. One result goes out
//   per cycle while out_ready is high, and bytes that only extend a run go
//   in at one per cycle while the queue is not full.
//   A two-entry command queue sits between the front and back parts; when
//   the receiver stalls, the queue fills and in_ready drops.
//   Reset (rst_n low, synchronous) closes any open run, empties the queue
//   and clears out_valid.
// ----------------------------------------------------------------------------
module rle_decimal_count_encoder #(
  parameter int MaxDigits = rle_enc_pkg::MaxDigitsDef
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_final_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_code_byte,
  output logic       out_last_of_item,
  output logic       out_stream_done
);

  localparam int LenW  = 4 * MaxDigits;
  localparam int CmdW  = $bits(rle_enc_pkg::rle_cmd_t);
  localparam int DataW = CmdW + LenW;

  logic                  push;
  rle_enc_pkg::rle_cmd_t push_cmd;
  logic [LenW-1:0]       push_len;
  logic                  q_full;
  logic                  q_pop;
  logic                  q_valid;
  logic [DataW-1:0]      q_data;
  rle_enc_pkg::rle_cmd_t head_cmd;
  logic [LenW-1:0]       head_len;

  rle_enc_front #(
    .MaxDigits(MaxDigits)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data_byte  (in_data_byte),
    .in_final_byte (in_final_byte),
    .q_push        (push),
    .q_cmd         (push_cmd),
    .q_len         (push_len),
    .q_full        (q_full)
  );

  rle_enc_queue #(
    .DataW(DataW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_cmd, push_len}),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .not_empty (q_valid)
  );

  assign head_cmd = rle_enc_pkg::rle_cmd_t'(q_data[DataW-1:LenW]);
  assign head_len = q_data[LenW-1:0];

  rle_enc_back #(
    .MaxDigits(MaxDigits)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_cmd            (head_cmd),
    .q_len            (head_len),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_code_byte    (out_code_byte),
    .out_last_of_item (out_last_of_item),
    .out_stream_done  (out_stream_done)
  );

endmodule

[tb/rle_decimal_count_encoder_tb.sv]
// ----------------------------------------------------------------------------
// rle_decimal_count_encoder_tb
// Self-checking testbench for the run-length encoder with decimal counts.
// A queue of raw bytes feeds a clocked driver on the input channel. Each
// accepted byte runs through an in-bench encoder model that queues the code
// bytes it should cause. A clocked monitor on the output channel checks every
// code byte and its flags against that queue. The stimulus covers directed
// corner cases, random streams under three idling mixes, a long receiver
// hold-off, and runs with three-digit counts.
// ----------------------------------------------------------------------------
module rle_decimal_count_encoder_tb;

  localparam int NDig   = rle_enc_pkg::MaxDigitsDef;
  localparam int RunCap = 10 ** NDig - 1;

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
  } raw_byte_t;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
    logic       done;
  } code_byte_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_data_byte = 8'h00;
  logic       in_final_byte = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_code_byte;
  logic       out_last_of_item;
  logic       out_stream_done;

  raw_byte_t  raw_bytes_q[$];
  code_byte_t expected_codes[$];

  // Encoder model state.
  logic [7:0]  run_byte = 8'h00;
  int unsigned run_cnt = 0;
  bit          run_active = 1'b0;

  int  fault_cnt = 0;
  int  tx_idle_pct = 36;
  int  rx_idle_pct = 60;
  int  phase_num = 0;
  bit  rx_hold = 1'b0;

  rle_decimal_count_encoder DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_final_byte    (in_final_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_code_byte    (out_code_byte),
    .out_last_of_item (out_last_of_item),
    .out_stream_done  (out_stream_done)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Writes the open run as decimal digits followed by its byte, then closes it.
  task automatic emit_run_codes();
    string digits;
    digits = $sformatf("%0d", run_cnt);
    for (int i = 0; i < digits.len(); i++) begin
      expected_codes.push_back('{code: digits[i], last: 1'b0, done: 1'b0});
    end
    expected_codes.push_back('{code: run_byte, last: 1'b0, done: 1'b0});
    run_active = 1'b0;
    run_cnt = 0;
  endtask

  task automatic encode_next_byte(input logic [7:0] b, input logic fin);
    int         first;
    code_byte_t tail;
    first = expected_codes.size();
    if (run_active && run_byte == b) begin
      run_cnt++;
      if (run_cnt == RunCap) begin
        emit_run_codes();
      end
    end else begin
      if (run_active) begin
        emit_run_codes();
      end
      run_byte = b;
      run_cnt = 1;
      run_active = 1'b1;
    end
    if (fin) begin
      if (run_active) begin
        emit_run_codes();
      end
      run_byte = 8'h00;
      run_cnt = 0;
      run_active = 1'b0;
    end
    if (expected_codes.size() > first) begin
      tail = expected_codes.pop_back();
      tail.last = 1'b1;
      tail.done = fin;
      expected_codes.push_back(tail);
    end
  endtask

  task automatic push_byte(input logic [7:0] b, input logic fin);
    raw_bytes_q.push_back('{data: b, fin: fin});
  endtask

  task automatic push_run(input logic [7:0] b, input int len, input logic fin);
    for (int i = 0; i < len; i++) begin
      push_byte(b, fin && (i == len - 1));
    end
  endtask

  // Random streams: mostly short runs, some with two- and three-digit counts.
  // Streams end at random, sometimes in the middle of a run.
  task automatic push_random_bytes(input int n);
    int         added;
    int         len;
    int         pick;
    logic [7:0] b;
    logic       fin;
    added = 0;
    b = 8'h00;
    while (added < n) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        len = $urandom_range(3, 1);
      end else if (pick < 92) begin
        len = $urandom_range(12, 4);
      end else begin
        len = $urandom_range(120, 13);
      end
      pick = $urandom_range(99);
      if (pick < 80) begin
        b = 8'($urandom);
      end else if (pick < 87) begin
        b = 8'h00;
      end else if (pick < 94) begin
        b = 8'hFF;
      end
      for (int i = 0; i < len && added < n; i++) begin
        fin = ((i == len - 1) && $urandom_range(99) < 20) || ($urandom_range(99) < 2);
        push_byte(b, fin);
        added++;
        if (fin) begin
          break;
        end
      end
    end
  endtask

  task automatic note_fault(input string msg);
    fault_cnt++;
    if (fault_cnt <= 10) begin
      $display("%s", msg);
    end
  endtask

  task automatic wait_drained();
    while (raw_bytes_q.size() != 0 || expected_codes.size() != 0 || in_valid) begin
      @(negedge clk);
    end
  endtask

  always @(posedge clk) begin : byte_driver
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        encode_next_byte(in_data_byte, in_final_byte);
        void'(raw_bytes_q.pop_front());
      end
      if (in_valid && !in_ready) begin
        // The item stays on the port until the block takes it.
      end else if (raw_bytes_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        in_valid      <= 1'b1;
        in_data_byte  <= raw_bytes_q[0].data;
        in_final_byte <= raw_bytes_q[0].fin;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : code_monitor
    code_byte_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_codes.size() == 0) begin
          note_fault($sformatf("unexpected code byte %02h last=%0b done=%0b",
                               out_code_byte, out_last_of_item, out_stream_done));
        end else begin
          want = expected_codes.pop_front();
          if (out_code_byte !== want.code || out_last_of_item !== want.last ||
              out_stream_done !== want.done) begin
            note_fault($sformatf({"code byte mismatch: expected %02h last=%0b done=%0b,",
                                  " got %02h last=%0b done=%0b"},
                                 want.code, want.last, want.done,
                                 out_code_byte, out_last_of_item, out_stream_done));
          end
        end
      end
      out_ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Long receiver stall early in the last phase, so the command queue fills
  // and the input side backs up.
  initial begin : rx_holdoff
    wait (phase_num == 2);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (400) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin : stimulus
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Single-byte streams at both ends of the byte range.
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b1);
    // Run of three zeros closed by a differing final byte.
    push_run(8'h00, 3, 1'b0);
    push_byte(8'hFF, 1'b1);
    // A count with a zero low digit, then a run of two ended by final.
    push_run(8'h41, 10, 1'b0);
    push_run(8'h42, 2, 1'b1);
    // Alternating bytes, each after the first closes the previous run.
    push_byte(8'h55, 1'b0);
    push_byte(8'hAA, 1'b0);
    push_byte(8'h55, 1'b1);
    push_random_bytes(115);
    wait_drained();

    tx_idle_pct = 60;
    rx_idle_pct = 36;
    push_random_bytes(115);
    wait_drained();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    push_random_bytes(115);
    push_byte(8'h7E, 1'b1);
    // A three-digit run closed by a differing final byte: an old run and a
    // new one of length one come out of the same item.
    push_run(8'hC3, 123, 1'b0);
    push_byte(8'h3C, 1'b1);
    phase_num = 2;
    wait_drained();

    repeat (20) @(posedge clk);
    if (fault_cnt == 0 && expected_codes.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : watchdog
    #4000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
